>>> sv/teha_pkg.sv
package teha_pkg;

    // Field and datapath widths
    localparam int OFS_W      = 32;             // width of one mark
    localparam int SUM_W      = OFS_W + 2;      // adder width, wide enough for every sum
    localparam int OUT_W      = 32;             // width of the result fields
    localparam int SIZE_W     = 31;             // request_size and hunk_size
    localparam int LG_W       = 4;              // align_log2
    localparam int KIND_W     = 3;
    localparam int STAT_W     = 2;
    localparam int STEP_W     = 3;

    localparam logic [LG_W-1:0] MAX_ALIGN_LOG2 = LG_W'(12);
    localparam logic [SIZE_W-1:0] HUNK_SIZE_RST = SIZE_W'(134217728);

    // Temporary allocations align to 16 bytes; low temporary ones carry a 16-byte header
    localparam logic [SUM_W-1:0] TMP_ROUND = SUM_W'(15);
    localparam logic [SUM_W-1:0] TMP_HDR   = SUM_W'(16);

    // Stream packing
    localparam int S_DATA_W = 40;               // size + align_log2, padded to bytes
    localparam int S_USER_W = KIND_W;
    localparam int M_DATA_W = 4 * OUT_W;
    localparam int M_USER_W = STAT_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUNK_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUNK_ENABLED = 1'b1;

    // Request kinds
    localparam logic [KIND_W-1:0] K_HIGH_PERM = 3'd0;
    localparam logic [KIND_W-1:0] K_LOW_PERM  = 3'd1;
    localparam logic [KIND_W-1:0] K_HIGH_TEMP = 3'd2;
    localparam logic [KIND_W-1:0] K_LOW_TEMP  = 3'd3;
    localparam logic [KIND_W-1:0] K_RESIZE    = 3'd4;
    localparam logic [KIND_W-1:0] K_CLEAR     = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOREGION = 2'd2;
    localparam logic [STAT_W-1:0] ST_FALLBACK = 2'd3;

    // Adder operand A
    typedef enum logic [3:0] {
        A_HP, A_LP, A_HT, A_LT, A_ACC, A_BASE, A_CHK, A_HS, A_OFF
    } t_asel;

    // Adder operand B
    typedef enum logic [3:0] {
        B_ZERO, B_SIZE, B_AMASK, B_ROUND, B_HDR, B_LT, B_HT, B_LP, B_HP, B_ACC, B_HS
    } t_bsel;

    // Mask applied to the adder result
    typedef enum logic [1:0] {
        M_NONE, M_ALIGN, M_TMP
    } t_msel;

    // Destination of the adder result
    typedef enum logic [2:0] {
        D_NONE, D_ACC, D_BASE, D_CHK, D_UTMP, D_OFF, D_HDR, D_SHORT
    } t_dst;

    // Mark update at the end of a request
    typedef enum logic [2:0] {
        C_NONE, C_HP, C_LP, C_HT, C_LT, C_CLR
    } t_commit;

    // One micro-operation of the shared adder
    typedef struct packed {
        t_asel asel;
        t_bsel bsel;
        logic  sub;
        t_msel msel;
        t_dst  dst;
    } t_uop;

    // Sequencer strobes toward the datapath
    typedef struct packed {
        logic              go;
        logic              finish;
        logic [STAT_W-1:0] status;
        t_commit           commit;
    } t_strobe;

    // Sequencer state
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } t_state;

endpackage

>>> sv/teha_alu.sv
module teha_alu (
    input  logic [teha_pkg::SUM_W-1:0] i_a,
    input  logic [teha_pkg::SUM_W-1:0] i_b,
    input  logic                       i_sub,
    input  teha_pkg::t_msel            i_msel,
    input  logic [teha_pkg::SUM_W-1:0] i_amask,
    output logic [teha_pkg::SUM_W-1:0] o_y
);
    import teha_pkg::*;

    logic [SUM_W-1:0] w_b;
    logic [SUM_W-1:0] w_sum;

    // Add, or subtract through the inverted operand and a carry in
    assign w_b   = i_sub ? ~i_b : i_b;
    assign w_sum = i_a + w_b + SUM_W'(i_sub);

    // Round down to the selected alignment
    always_comb begin
        unique case (i_msel)
            M_ALIGN: o_y = w_sum & ~i_amask;
            M_TMP:   o_y = w_sum & ~TMP_ROUND;
            default: o_y = w_sum;
        endcase
    end

endmodule

>>> sv/teha_ctrl.sv
module teha_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [teha_pkg::KIND_W-1:0] i_kind,
    input  logic                        i_en,
    input  logic                        i_over,
    input  logic                        i_out_free,
    output logic                        o_ready,
    output teha_pkg::t_uop              o_uop,
    output teha_pkg::t_strobe           o_strobe
);
    import teha_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [KIND_W-1:0]   r_kind;

    t_uop                w_uop;
    logic                w_fin;
    logic                w_test;
    logic [STAT_W-1:0]   w_stat;
    t_commit             w_commit;
    logic                w_go;

    // Decode the micro-operation for the current kind and step
    always_comb begin
        w_uop    = '{asel: A_ACC, bsel: B_ZERO, sub: 1'b0, msel: M_NONE, dst: D_NONE};
        w_fin    = 1'b0;
        w_test   = 1'b0;
        w_stat   = ST_OK;
        w_commit = C_NONE;
        unique case (r_kind)
            K_HIGH_PERM: begin
                if (!i_en) begin
                    w_fin  = 1'b1;
                    w_stat = ST_NOREGION;
                end else begin
                    unique case (r_step)
                        3'd0: w_uop = '{A_HP, B_SIZE, 1'b0, M_NONE, D_ACC};
                        3'd1: w_uop = '{A_ACC, B_AMASK, 1'b0, M_ALIGN, D_ACC};
                        3'd2: w_uop = '{A_ACC, B_LT, 1'b0, M_NONE, D_CHK};
                        3'd3: begin
                            w_uop  = '{A_ACC, B_LP, 1'b0, M_NONE, D_UTMP};
                            w_test = 1'b1;
                        end
                        default: begin
                            w_uop    = '{A_HS, B_ACC, 1'b1, M_NONE, D_OFF};
                            w_fin    = 1'b1;
                            w_commit = C_HP;
                        end
                    endcase
                end
            end
            K_LOW_PERM: begin
                unique case (r_step)
                    3'd0: w_uop = '{A_LP, B_AMASK, 1'b0, M_ALIGN, D_BASE};
                    3'd1: w_uop = '{A_BASE, B_SIZE, 1'b0, M_NONE, D_ACC};
                    3'd2: w_uop = '{A_ACC, B_HT, 1'b0, M_NONE, D_CHK};
                    3'd3: begin
                        w_uop  = '{A_ACC, B_HP, 1'b0, M_NONE, D_UTMP};
                        w_test = 1'b1;
                    end
                    default: begin
                        w_uop    = '{A_BASE, B_ZERO, 1'b0, M_NONE, D_OFF};
                        w_fin    = 1'b1;
                        w_commit = C_LP;
                    end
                endcase
            end
            K_HIGH_TEMP: begin
                unique case (r_step)
                    3'd0: w_uop = '{A_HT, B_SIZE, 1'b0, M_NONE, D_ACC};
                    3'd1: w_uop = '{A_ACC, B_ROUND, 1'b0, M_TMP, D_ACC};
                    3'd2: w_uop = '{A_ACC, B_LT, 1'b0, M_NONE, D_CHK};
                    default: begin
                        w_uop    = '{A_HS, B_ACC, 1'b1, M_NONE, D_OFF};
                        w_test   = 1'b1;
                        w_fin    = 1'b1;
                        w_commit = C_HT;
                    end
                endcase
            end
            K_LOW_TEMP: begin
                if (!i_en) begin
                    w_fin  = 1'b1;
                    w_stat = ST_FALLBACK;
                end else begin
                    unique case (r_step)
                        3'd0: w_uop = '{A_LT, B_ROUND, 1'b0, M_TMP, D_BASE};
                        3'd1: w_uop = '{A_BASE, B_HDR, 1'b0, M_NONE, D_OFF};
                        3'd2: w_uop = '{A_OFF, B_SIZE, 1'b0, M_NONE, D_ACC};
                        3'd3: w_uop = '{A_ACC, B_HT, 1'b0, M_NONE, D_CHK};
                        default: begin
                            w_fin = 1'b1;
                            // Out of space reports how many bytes are missing
                            if (i_over) begin
                                w_uop  = '{A_CHK, B_HS, 1'b1, M_NONE, D_SHORT};
                                w_stat = ST_NOSPACE;
                            end else begin
                                w_uop    = '{A_ACC, B_LT, 1'b1, M_NONE, D_HDR};
                                w_commit = C_LT;
                            end
                        end
                    endcase
                end
            end
            K_RESIZE: begin
                unique case (r_step)
                    3'd0: w_uop = '{A_LP, B_SIZE, 1'b0, M_NONE, D_ACC};
                    3'd1: w_uop = '{A_ACC, B_HT, 1'b0, M_NONE, D_CHK};
                    default: begin
                        w_uop    = '{A_LP, B_ZERO, 1'b0, M_NONE, D_OFF};
                        w_test   = 1'b1;
                        w_fin    = 1'b1;
                        w_commit = C_LT;
                    end
                endcase
            end
            K_CLEAR: begin
                w_fin = 1'b1;
                if (i_en) begin
                    w_commit = C_CLR;
                end else begin
                    w_stat = ST_NOREGION;
                end
            end
            default: begin
                w_fin = 1'b1;
            end
        endcase

        // A failed space check ends the request and keeps every mark
        if (w_test && i_over) begin
            w_fin    = 1'b1;
            w_stat   = ST_NOSPACE;
            w_commit = C_NONE;
        end
    end

    // Hold the final step until the result register can take it
    assign w_go = (r_state == S_BUSY) && (!w_fin || i_out_free);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_BUSY;
                    n_step  = '0;
                end
            end
            S_BUSY: begin
                if (w_go) begin
                    if (w_fin) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step = r_step + STEP_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Latch the request kind on transfer
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_kind <= i_kind;
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_uop    = w_uop;
    assign o_strobe = '{go: w_go, finish: w_fin, status: w_stat, commit: w_commit};

endmodule

>>> sv/two_ended_hunk_allocator.sv
// Channel   Dir  tdata (low bit up)                           tuser
// s_axis    in   request_size[30:0], align_log2[34:31], pad   kind[2:0]
// m_axis    out  block_offset, header_length, usage_total,    status[1:0]
//                shortfall (32 bits each)
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, write only
//
// A request is transferred and then carried out as a sequence of steps of the
// shared adder. A permanent kind that fails its space check ends early; clear,
// unknown kinds and a high permanent or low temporary request while disabled end
// in their first step. Synchronous active-low reset clears all marks and usage.
// s_axis_tready stays low during a request; its last step waits while the
// result register is full and not being taken.
module two_ended_hunk_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [teha_pkg::S_DATA_W-1:0]   s_axis_tdata,  // request_size, align_log2
    input  logic [teha_pkg::S_USER_W-1:0]   s_axis_tuser,  // kind
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [teha_pkg::M_DATA_W-1:0]   m_axis_tdata,  // offset, header, usage, shortfall
    output logic [teha_pkg::M_USER_W-1:0]   m_axis_tuser,  // status
    // Configuration writes
    input  logic                            i_cfg_we,
    input  logic [teha_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [teha_pkg::SIZE_W-1:0]     i_cfg_data
);
    import teha_pkg::*;

    // Configuration
    logic [SIZE_W-1:0] r_hs;
    logic              r_en;

    // Marks and usage
    logic [OFS_W-1:0]  r_lp, r_lt, r_hp, r_ht;
    logic [OUT_W-1:0]  r_use, n_use;

    // Request and working registers
    logic [SIZE_W-1:0] r_size;
    logic [LG_W-1:0]   r_lg;
    logic [SUM_W-1:0]  r_acc, r_base, r_chk, r_utmp;
    logic [OUT_W-1:0]  r_off, r_hdr, r_short;
    logic [OUT_W-1:0]  n_off, n_hdr, n_short;

    // Result register
    logic              r_ovalid;
    logic [STAT_W-1:0] r_ostat;
    logic [OUT_W-1:0]  r_ooff, r_ohdr, r_ouse, r_oshort;

    logic              w_start;
    logic              w_ready;
    logic              w_over;
    logic              w_out_free;
    t_uop              w_uop;
    t_strobe           w_stb;
    logic [LG_W-1:0]   w_lg_sat;
    logic [SUM_W-1:0]  w_amask;
    logic [SUM_W-1:0]  w_a, w_b, w_y;

    assign s_axis_tready = w_ready;
    assign w_start       = s_axis_tvalid && w_ready;
    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign w_over        = r_chk > SUM_W'(r_hs);

    teha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_kind     (s_axis_tuser),
        .i_en       (r_en),
        .i_over     (w_over),
        .i_out_free (w_out_free),
        .o_ready    (w_ready),
        .o_uop      (w_uop),
        .o_strobe   (w_stb)
    );

    // Alignment mask, large alignments saturate
    assign w_lg_sat = (r_lg > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : r_lg;
    assign w_amask  = (SUM_W'(1) << w_lg_sat) - SUM_W'(1);

    // Operand selection for the shared adder
    always_comb begin
        unique case (w_uop.asel)
            A_HP:    w_a = SUM_W'(r_hp);
            A_LP:    w_a = SUM_W'(r_lp);
            A_HT:    w_a = SUM_W'(r_ht);
            A_LT:    w_a = SUM_W'(r_lt);
            A_ACC:   w_a = r_acc;
            A_BASE:  w_a = r_base;
            A_CHK:   w_a = r_chk;
            A_HS:    w_a = SUM_W'(r_hs);
            A_OFF:   w_a = SUM_W'(r_off);
            default: w_a = '0;
        endcase
        unique case (w_uop.bsel)
            B_SIZE:  w_b = SUM_W'(r_size);
            B_AMASK: w_b = w_amask;
            B_ROUND: w_b = TMP_ROUND;
            B_HDR:   w_b = TMP_HDR;
            B_LT:    w_b = SUM_W'(r_lt);
            B_HT:    w_b = SUM_W'(r_ht);
            B_LP:    w_b = SUM_W'(r_lp);
            B_HP:    w_b = SUM_W'(r_hp);
            B_ACC:   w_b = r_acc;
            B_HS:    w_b = SUM_W'(r_hs);
            default: w_b = '0;
        endcase
    end

    teha_alu u_alu (
        .i_a     (w_a),
        .i_b     (w_b),
        .i_sub   (w_uop.sub),
        .i_msel  (w_uop.msel),
        .i_amask (w_amask),
        .o_y     (w_y)
    );

    // Result fields as they stand after this step
    assign n_off   = (w_stb.go && w_uop.dst == D_OFF)   ? w_y[OUT_W-1:0] : r_off;
    assign n_hdr   = (w_stb.go && w_uop.dst == D_HDR)   ? w_y[OUT_W-1:0] : r_hdr;
    assign n_short = (w_stb.go && w_uop.dst == D_SHORT) ? w_y[OUT_W-1:0] : r_short;

    always_comb begin
        n_use = r_use;
        if (w_stb.go) begin
            unique case (w_stb.commit)
                C_HP, C_LP: n_use = r_utmp[OUT_W-1:0];
                C_CLR:      n_use = '0;
                default:    n_use = r_use;
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs <= HUNK_SIZE_RST;
            r_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HUNK_SIZE:    r_hs <= i_cfg_data;
                CFG_HUNK_ENABLED: r_en <= i_cfg_data[0];
                default:          r_en <= r_en;
            endcase
        end
    end

    // Update marks at the end of a successful request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp  <= '0;
            r_lt  <= '0;
            r_hp  <= '0;
            r_ht  <= '0;
            r_use <= '0;
        end else if (w_stb.go) begin
            r_use <= n_use;
            unique case (w_stb.commit)
                C_HP: begin
                    r_hp <= r_acc[OFS_W-1:0];
                    r_ht <= r_acc[OFS_W-1:0];
                end
                C_LP: begin
                    r_lp <= r_acc[OFS_W-1:0];
                    r_lt <= r_acc[OFS_W-1:0];
                end
                C_HT: r_ht <= r_acc[OFS_W-1:0];
                C_LT: r_lt <= r_acc[OFS_W-1:0];
                C_CLR: begin
                    r_lp <= '0;
                    r_lt <= '0;
                    r_hp <= '0;
                    r_ht <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Latch the request and clear the result fields on transfer
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_size  <= s_axis_tdata[SIZE_W-1:0];
            r_lg    <= s_axis_tdata[SIZE_W+LG_W-1:SIZE_W];
            r_off   <= '0;
            r_hdr   <= '0;
            r_short <= '0;
        end else begin
            r_off   <= n_off;
            r_hdr   <= n_hdr;
            r_short <= n_short;
        end
    end

    // Write the adder result to its working register
    always_ff @(posedge i_clk) begin
        if (w_stb.go) begin
            unique case (w_uop.dst)
                D_ACC:   r_acc  <= w_y;
                D_BASE:  r_base <= w_y;
                D_CHK:   r_chk  <= w_y;
                D_UTMP:  r_utmp <= w_y;
                default: r_acc  <= r_acc;
            endcase
        end
    end

    // Result register: load on the final step, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_stb.go && w_stb.finish) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stb.go && w_stb.finish) begin
            r_ostat  <= w_stb.status;
            r_ooff   <= (w_stb.status == ST_OK) ? n_off : '0;
            r_ohdr   <= n_hdr;
            r_ouse   <= n_use;
            r_oshort <= n_short;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostat;
    assign m_axis_tdata  = {r_oshort, r_ouse, r_ohdr, r_ooff};

endmodule
